// ===== src/tlm_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-list merge package
// Shared constants, types and codes for the two-list merge unit.
// ----------------------------------------------------------------------------
package tlm_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 2;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [SUM_W-1:0]         sum_type;

   // Command codes carried on the request channel.
   localparam cmd_type CMD_LOAD_A = 2'd0;
   localparam cmd_type CMD_LOAD_B = 2'd1;
   localparam cmd_type CMD_START  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PICK
   } state_type;

   // Status from the merge sequencer to the top level.
   typedef struct packed {
      logic busy;
      logic done;
   } status_type;

endpackage

// ===== src/tlm_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries a command and an element value.
// ----------------------------------------------------------------------------
interface tlm_req_if;
   logic               valid;
   logic               ready;
   tlm_pkg::cmd_type   cmd;
   tlm_pkg::data_type  value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== src/tlm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries one merged element and its last flag.
// ----------------------------------------------------------------------------
interface tlm_rsp_if;
   logic               valid;
   logic               ready;
   tlm_pkg::data_type  value_res;
   logic               last;

   modport source (output valid, output value_res, output last, input ready);
   modport sink   (input valid, input value_res, input last, output ready);
endinterface

// ===== src/tlm_list_ram.sv =====
// ----------------------------------------------------------------------------
// List storage
// Single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tlm_list_ram (
   input  logic              clock,
   input  logic              wr_en,
   input  tlm_pkg::idx_type  wr_addr,
   input  tlm_pkg::data_type wr_data,
   input  tlm_pkg::idx_type  rd_addr,
   output tlm_pkg::data_type rd_data
);
   import tlm_pkg::*;

   data_type mem [LIST_DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/tlm_merge_ctrl.sv =====
// ----------------------------------------------------------------------------
// Merge sequencer
// Walks both lists with one shared signed compare and drives the response
// register, one element at a time: a read step, then a compare step.
// ----------------------------------------------------------------------------
module tlm_merge_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tlm_pkg::cnt_type    count_a,
   input  tlm_pkg::cnt_type    count_b,
   output tlm_pkg::idx_type    rd_addr_a,
   output tlm_pkg::idx_type    rd_addr_b,
   input  tlm_pkg::data_type   rd_data_a,
   input  tlm_pkg::data_type   rd_data_b,
   output tlm_pkg::status_type status,
   tlm_rsp_if.source           rsp_chan
);
   import tlm_pkg::*;

   state_type state_ff, state_in;
   cnt_type   ia_ff, ia_in;
   cnt_type   ib_ff, ib_in;
   logic      valid_ff, valid_in;
   data_type  value_ff, value_in;
   logic      last_ff, last_in;

   logic      out_free;
   logic      take_b;
   sum_type   total;
   sum_type   next_k;
   logic      is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff    <= ia_in;
      ib_ff    <= ib_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign total    = {1'b0, count_a} + {1'b0, count_b};
   assign next_k   = {1'b0, ia_ff} + {1'b0, ib_ff} + SUM_W'(1);
   assign is_last  = (next_k == total);
   assign out_free = !valid_ff || rsp_chan.ready;
   // B wins when A is used up, and also on a tie.
   assign take_b   = (ia_ff >= count_a) ||
                     ((ib_ff < count_b) && !(rd_data_a < rd_data_b));

   always_comb begin
      state_in    = state_ff;
      ia_in       = ia_ff;
      ib_in       = ib_ff;
      valid_in    = valid_ff && !rsp_chan.ready;
      value_in    = value_ff;
      last_in     = last_ff;
      status.busy = (state_ff != ST_IDLE);
      status.done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start && (total != '0)) begin
               ia_in    = '0;
               ib_in    = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (out_free) begin
               valid_in = 1'b1;
               last_in  = is_last;
               if (take_b) begin
                  value_in = rd_data_b;
                  ib_in    = ib_ff + CNT_W'(1);
               end else begin
                  value_in = rd_data_a;
                  ia_in    = ia_ff + CNT_W'(1);
               end
               if (is_last) begin
                  status.done = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr_a = ia_ff[IDX_W-1:0];
   assign rd_addr_b = ib_ff[IDX_W-1:0];

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.value_res = value_ff;
   assign rsp_chan.last      = last_ff;
endmodule

// ===== src/two_list_merge_unit.sv =====
// ----------------------------------------------------------------------------
// Two-list merge unit
// Stores two lists of signed 32-bit elements and emits their sorted merge.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries a command and a value. A load-A or load-B
// transaction appends the value to that list; a load into a full list is
// dropped. Unused command code 3 is accepted and ignored.
// A start transaction merges both lists onto the response channel, smallest
// element first, taking from list B when the heads are equal, and flags the
// final element with last. Both lists are then empty again.
// Each merged element passes a read step, the registered memory read of
// both list heads, and then a compare step, the shared signed compare that
// loads the response register. The request channel is held for the whole
// merge; a start with both lists empty is a no-op.
// The response register decouples the two channels: loads are accepted
// while the final element of a merge still waits to be taken. When the
// receiver stalls, the sequencer holds in its compare step.
// Reset empties both lists and clears the response valid flag; list contents
// are not cleared and are read only after they have been written.
// ----------------------------------------------------------------------------
module two_list_merge_unit (
   input  logic      clock,
   input  logic      reset,
   tlm_req_if.sink   req_chan,
   tlm_rsp_if.source rsp_chan
);
   import tlm_pkg::*;

   cnt_type    count_a_ff, count_a_in;
   cnt_type    count_b_ff, count_b_in;
   logic       req_fire;
   logic       wr_en_a;
   logic       wr_en_b;
   logic       start;
   idx_type    rd_addr_a;
   idx_type    rd_addr_b;
   data_type   rd_data_a;
   data_type   rd_data_b;
   status_type status;

   // Requests are taken only while the sequencer is idle.
   assign req_chan.ready = !status.busy;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // A load beyond the list depth is dropped and leaves its count alone.
   assign wr_en_a = req_fire && (req_chan.cmd == CMD_LOAD_A) &&
                    (count_a_ff < CNT_W'(LIST_DEPTH));
   assign wr_en_b = req_fire && (req_chan.cmd == CMD_LOAD_B) &&
                    (count_b_ff < CNT_W'(LIST_DEPTH));
   assign start   = req_fire && (req_chan.cmd == CMD_START);

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (status.done) begin
         count_a_in = '0;
         count_b_in = '0;
      end else begin
         if (wr_en_a) begin
            count_a_in = count_a_ff + CNT_W'(1);
         end
         if (wr_en_b) begin
            count_b_in = count_b_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

   tlm_list_ram u_list_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (count_a_ff[IDX_W-1:0]),
      .wr_data (req_chan.value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   tlm_list_ram u_list_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (count_b_ff[IDX_W-1:0]),
      .wr_data (req_chan.value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   tlm_merge_ctrl u_merge_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .count_a   (count_a_ff),
      .count_b   (count_b_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .status    (status),
      .rsp_chan  (rsp_chan)
   );
endmodule

// ===== src/tlm_checker.sv =====
// ----------------------------------------------------------------------------
// Two-list merge checker
// Port-level assertions for the two-list merge unit, bound to the top level.
// ----------------------------------------------------------------------------
module tlm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tlm_pkg::cmd_type  req_cmd,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tlm_pkg::data_type rsp_value_res,
   input logic              rsp_last
);
   import tlm_pkg::*;

   // A stalled response transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_res) && $stable(rsp_last))
      else $error("stalled response changed");

   // While a merge is still running, no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request ready during a merge");

   // A load or an ignored command never starts a response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != CMD_START) |=> !$rose(rsp_valid))
      else $error("response without a start");

   // The block only goes busy right after accepting a start.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && (req_cmd == CMD_START)))
      else $error("busy without a start");
endmodule

bind two_list_merge_unit tlm_checker u_tlm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_cmd       (req_chan.cmd),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_value_res (rsp_chan.value_res),
   .rsp_last      (rsp_chan.last)
);
